/* rtl/crt_pkg.sv */
// Package: widths and default parameters of the congruence combiner.
package crt_pkg;
  localparam int unsigned MODULUS_BITS_DEF = 31;
  localparam int unsigned ACCUM_BITS_DEF   = 63;
  localparam int unsigned RESIDUE_BITS     = 32;
  localparam int unsigned OUT_BITS         = 63;
endpackage

/* rtl/crt_congruence_combiner.sv */
// Congruence combiner: merges a run of congruences by extended Euclid into one solution.
//
//  channel | direction | fields                                         | handshake
//  in      | input     | residue_i, modulus_i, last_i                   | in_valid_i / in_ready_o
//  out     | output    | solution_o, combined_modulus_o, no_solution_o, | out_valid_o / out_ready_i
//          |           | overflow_o                                     |
//
// One beat at a time: a shared restoring divider and a shift-add multiplier run under the
// sequencer below; a merge runs one Euclid step after another and stops short where a
// conflict or overflow is found, and once the run is already flagged a beat only has its
// residue reduced.
// Reset clears the running congruence to x = 0 (mod 1); no clearing pass is needed.
// in_ready_o is high only in idle; a last beat waits at the end for a free output register.
module crt_congruence_combiner
  import crt_pkg::*;
#(
  parameter int unsigned MODULUS_BITS = MODULUS_BITS_DEF,
  parameter int unsigned ACCUM_BITS   = ACCUM_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [RESIDUE_BITS-1:0] residue_i,
  input  logic [MODULUS_BITS-1:0] modulus_i,
  input  logic                    last_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [OUT_BITS-1:0]     solution_o,
  output logic [OUT_BITS-1:0]     combined_modulus_o,
  output logic                    no_solution_o,
  output logic                    overflow_o
);

  localparam int unsigned W   = MODULUS_BITS;
  localparam int unsigned A   = ACCUM_BITS;
  localparam int unsigned MW  = (A > W) ? A : W;
  localparam int unsigned DW0 = (A > 2 * W) ? A : 2 * W;
  localparam int unsigned DW  = (DW0 > RESIDUE_BITS) ? DW0 : RESIDUE_BITS;
  localparam int unsigned CW  = $clog2(DW + 1);
  localparam int unsigned SW  = W + 2;
  localparam int unsigned PW  = MW + W;

  typedef enum logic [3:0] {
    S_IDLE, S_RED, S_MR, S_RR, S_ECHK, S_EUC, S_DG, S_N,
    S_MN, S_SM, S_DS, S_K, S_MK, S_DONE
  } state_e;

  state_e state_q;

  // shared units
  logic [DW-1:0]        dvd_q;
  logic [W-1:0]         rem_q, dsr_q;
  logic [CW-1:0]        cnt_q;
  logic [MW-1:0]        mca_q;
  logic [W-1:0]         mcb_q;
  logic [PW-1:0]        acc_q;

  // merge state
  logic [A-1:0]         m_q, r_q, p_q;
  logic                 conf_q, ovf_q, start_q;
  logic [W-1:0]         m2_q, red_q, d_q, za_q, zb_q, dg_q, n_q, sn_q;
  logic signed [SW-1:0] sa_q, sb_q, prod_q;
  logic                 neg_q, sneg_q, last_q;

  // output register
  logic                 ov_q, ns_q, of_q;
  logic [OUT_BITS-1:0]  sol_q, cm_q;

  // divider step
  logic [W:0]           rem_sh, rem_sub;
  logic                 ge;
  logic [W-1:0]         rem_n;
  logic signed [SW-1:0] prod_n;
  logic [PW-1:0]        acc_n;
  logic [W:0]           d_diff;
  logic [RESIDUE_BITS-1:0] mag;
  logic [W-1:0]         m2_in, sabs;

  assign rem_sh  = {rem_q, dvd_q[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign ge      = rem_sh >= {1'b0, dsr_q};
  assign rem_n   = ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
  assign prod_n  = (prod_q <<< 1) + (ge ? sb_q : SW'(0));

  // multiplier step, MSB of multiplier first
  assign acc_n = {acc_q[PW-2:0], 1'b0} + (mcb_q[W-1] ? PW'(mca_q) : PW'(0));

  // operand preparation
  assign mag    = residue_i[RESIDUE_BITS-1] ? (~residue_i + 1'b1) : residue_i;
  assign m2_in  = (modulus_i == '0) ? W'(1) : modulus_i;
  assign d_diff = {1'b0, red_q} - {1'b0, rem_q};
  assign sabs   = sa_q[SW-1] ? W'(-sa_q) : W'(sa_q);

  assign in_ready_o         = (state_q == S_IDLE);
  assign out_valid_o        = ov_q;
  assign solution_o         = sol_q;
  assign combined_modulus_o = cm_q;
  assign no_solution_o      = ns_q;
  assign overflow_o         = of_q;

  // sequencer, datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      m_q     <= A'(1);
      r_q     <= '0;
      conf_q  <= 1'b0;
      ovf_q   <= 1'b0;
      start_q <= 1'b1;
      ov_q    <= 1'b0;
    end else begin
      if (ov_q && out_ready_i && !(state_q == S_DONE && last_q)) ov_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            neg_q  <= residue_i[RESIDUE_BITS-1];
            last_q <= last_i;
            m2_q   <= m2_in;
            dvd_q  <= DW'(mag);
            dsr_q  <= m2_in;
            rem_q  <= '0;
            cnt_q  <= CW'(DW);
            state_q <= S_RED;
          end
        end
        S_RED, S_MR, S_RR, S_EUC, S_DG, S_N, S_SM, S_K: begin
          if (cnt_q != '0) begin
            rem_q  <= rem_n;
            dvd_q  <= {dvd_q[DW-2:0], ge};
            prod_q <= prod_n;
            cnt_q  <= cnt_q - 1'b1;
          end else begin
            unique case (state_q)
              S_RED: begin
                red_q <= (neg_q && rem_q != '0) ? m2_q - rem_q : rem_q;
                if (start_q || (!conf_q && !ovf_q)) begin
                  if (start_q) begin
                    m_q    <= A'(1);
                    r_q    <= '0;
                    conf_q <= 1'b0;
                    ovf_q  <= 1'b0;
                    start_q <= 1'b0;
                  end
                  dvd_q  <= start_q ? DW'(1) : DW'(m_q);
                  dsr_q  <= m2_q;
                  rem_q  <= '0;
                  cnt_q  <= CW'(DW);
                  state_q <= S_MR;
                end else begin
                  state_q <= S_DONE;
                end
              end
              S_MR: begin
                za_q  <= rem_q;
                dvd_q <= DW'(r_q);
                rem_q <= '0;
                cnt_q <= CW'(DW);
                state_q <= S_RR;
              end
              S_RR: begin
                d_q  <= d_diff[W] ? d_diff[W-1:0] + m2_q : d_diff[W-1:0];
                zb_q <= m2_q;
                sa_q <= SW'(1);
                sb_q <= '0;
                state_q <= S_ECHK;
              end
              S_EUC: begin
                za_q <= zb_q;
                zb_q <= rem_q;
                sa_q <= sb_q;
                sb_q <= sa_q - prod_q;
                state_q <= S_ECHK;
              end
              S_DG: begin
                if (rem_q != '0) begin
                  conf_q  <= 1'b1;
                  state_q <= S_DONE;
                end else begin
                  dg_q  <= dvd_q[W-1:0];
                  dvd_q <= DW'(m2_q);
                  rem_q <= '0;
                  cnt_q <= CW'(DW);
                  state_q <= S_N;
                end
              end
              S_N: begin
                n_q   <= dvd_q[W-1:0];
                mca_q <= MW'(m_q);
                mcb_q <= dvd_q[W-1:0];
                acc_q <= '0;
                cnt_q <= CW'(W);
                state_q <= S_MN;
              end
              S_SM: begin
                sn_q  <= (sneg_q && rem_q != '0) ? n_q - rem_q : rem_q;
                mca_q <= MW'(dg_q);
                mcb_q <= (sneg_q && rem_q != '0) ? n_q - rem_q : rem_q;
                acc_q <= '0;
                cnt_q <= CW'(W);
                state_q <= S_DS;
              end
              default: begin
                // S_K: k is ready, form M * k
                mca_q <= MW'(m_q);
                mcb_q <= rem_q;
                acc_q <= '0;
                cnt_q <= CW'(W);
                state_q <= S_MK;
              end
            endcase
          end
        end
        S_ECHK: begin
          dvd_q  <= (zb_q == '0) ? DW'(d_q) : DW'(za_q);
          dsr_q  <= (zb_q == '0) ? za_q : zb_q;
          rem_q  <= '0;
          prod_q <= '0;
          cnt_q  <= CW'(DW);
          state_q <= (zb_q == '0) ? S_DG : S_EUC;
        end
        S_MN, S_DS, S_MK: begin
          if (cnt_q != '0) begin
            acc_q <= acc_n;
            mcb_q <= {mcb_q[W-2:0], 1'b0};
            cnt_q <= cnt_q - 1'b1;
          end else begin
            unique case (state_q)
              S_MN: begin
                if (acc_q[PW-1:A] != '0) begin
                  ovf_q   <= 1'b1;
                  state_q <= S_DONE;
                end else begin
                  p_q    <= acc_q[A-1:0];
                  sneg_q <= sa_q[SW-1];
                  dvd_q  <= DW'(sabs);
                  dsr_q  <= n_q;
                  rem_q  <= '0;
                  cnt_q  <= CW'(DW);
                  state_q <= S_SM;
                end
              end
              S_DS: begin
                dvd_q <= DW'(acc_q[2*W-1:0]);
                rem_q <= '0;
                cnt_q <= CW'(DW);
                state_q <= S_K;
              end
              default: begin
                r_q <= r_q + acc_q[A-1:0];
                m_q <= p_q;
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          if (!last_q) begin
            state_q <= S_IDLE;
          end else if (!ov_q || out_ready_i) begin
            ov_q    <= 1'b1;
            ns_q    <= conf_q;
            of_q    <= ovf_q && !conf_q;
            sol_q   <= (conf_q || ovf_q) ? '0 : OUT_BITS'(r_q);
            cm_q    <= conf_q ? OUT_BITS'(1) : OUT_BITS'(m_q | {A{ovf_q}});
            start_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // checks
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(no_solution_o && overflow_o))
    else $error("both result flags set");
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (no_solution_o || overflow_o)) |-> (solution_o == '0))
    else $error("flagged result carries a value");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DW))
    else $error("step counter out of range");
  a_start_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q == S_RED && cnt_q == CW'(DW)))
    else $error("beat did not start reduction");

endmodule
